@@ hw/rtl/sefr_pkg.sv @@
// Shared types and constants for the sync/enquiry frame receiver.
package sefr_pkg;

    // Limits of the handshake.
    localparam logic [15:0] START_WAIT_LIMIT = 16'd40000;
    localparam logic [12:0] MAX_FRAME        = 13'd4096;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_SYNC_CODE    = 3'd0,
        CFG_ENQUIRY_CODE = 3'd1,
        CFG_START_CODE   = 3'd2,
        CFG_END_CODE     = 3'd3,
        CFG_ACK_CODE     = 3'd4,
        CFG_NAK_CODE     = 3'd5,
        CFG_FRAME_LENGTH = 3'd6,
        CFG_BYTE_TIMEOUT = 3'd7
    } t_cfg_idx;

    // Input item kinds.
    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    // Receiver phase.
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_RECV = 2'd2
    } t_phase;

    // One result item.
    typedef struct packed {
        logic        send_valid;
        logic [7:0]  send_byte;
        logic        data_valid;
        logic [7:0]  data_byte;
        logic [11:0] data_index;
        logic        frame_done;
        logic        frame_ok;
    } t_result;

endpackage

@@ hw/rtl/sefr_if.sv @@
// Valid/ready channel interfaces for input items and result items.
interface sefr_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface sefr_out_if;
    logic        valid;
    logic        ready;
    logic        send_valid;
    logic [7:0]  send_byte;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [11:0] data_index;
    logic        frame_done;
    logic        frame_ok;

    modport source (output valid, output send_valid, output send_byte, output data_valid,
                    output data_byte, output data_index, output frame_done,
                    output frame_ok, input ready);
    modport sink   (input valid, input send_valid, input send_byte, input data_valid,
                    input data_byte, input data_index, input frame_done,
                    input frame_ok, output ready);
endinterface

@@ hw/rtl/sync_enquiry_frame_receiver.sv @@
// Receiver of the sync / enquiry / start / frame / ACK-NAK serial handshake.
// A result item is loaded into the output register as its input item is accepted.
// Throughput: one input item per cycle while the output register is empty or drained.
// Items that cause no result only update the phase and counters.
// Reset (synchronous, active low) restores the default codes and returns to idle.
module sync_enquiry_frame_receiver (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  sefr_pkg::t_cfg_idx         i_cfg_idx,
    input  logic [15:0]                i_cfg_data,
    sefr_in_if.sink                    i_rx,
    sefr_out_if.source                 o_res
);
    import sefr_pkg::*;

    // Configuration registers.
    logic [7:0]  r_sync_code, r_enquiry_code, r_start_code, r_end_code;
    logic [7:0]  r_ack_code, r_nak_code;
    logic [12:0] r_frame_length;
    logic [15:0] r_byte_timeout;

    // Receiver state.
    t_phase      r_phase, n_phase;
    logic [15:0] r_wait_remaining, n_wait_remaining;
    logic [12:0] r_bytes_received, n_bytes_received;
    logic [15:0] r_quiet_ticks, n_quiet_ticks;

    // Output register.
    logic        r_out_valid;
    t_result     r_out;
    t_result     n_res;

    logic        in_accept;
    logic        is_tick;
    logic        is_sync;
    logic [12:0] eff_length;
    logic [15:0] timeout_lim;
    logic [15:0] quiet_inc;
    logic [12:0] bytes_inc;
    logic        frame_end;
    logic        timed_out;

    // An item is taken whenever the output register is empty or being drained.
    assign i_rx.ready = !r_out_valid || o_res.ready;
    assign in_accept  = i_rx.valid && i_rx.ready;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_code    <= 8'd22;
            r_enquiry_code <= 8'd5;
            r_start_code   <= 8'd1;
            r_end_code     <= 8'd4;
            r_ack_code     <= 8'd6;
            r_nak_code     <= 8'd21;
            r_frame_length <= 13'd1;
            r_byte_timeout <= 16'd1000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SYNC_CODE:    r_sync_code    <= i_cfg_data[7:0];
                CFG_ENQUIRY_CODE: r_enquiry_code <= i_cfg_data[7:0];
                CFG_START_CODE:   r_start_code   <= i_cfg_data[7:0];
                CFG_END_CODE:     r_end_code     <= i_cfg_data[7:0];
                CFG_ACK_CODE:     r_ack_code     <= i_cfg_data[7:0];
                CFG_NAK_CODE:     r_nak_code     <= i_cfg_data[7:0];
                CFG_FRAME_LENGTH: r_frame_length <= i_cfg_data[12:0];
                CFG_BYTE_TIMEOUT: r_byte_timeout <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Decoded item and clamped limits.
    assign is_tick     = (t_op'(i_rx.op) == OP_TICK);
    assign is_sync     = !is_tick && (i_rx.rx_byte == r_sync_code);
    assign eff_length  = (r_frame_length == 13'd0) ? 13'd1 :
                         (r_frame_length > MAX_FRAME) ? MAX_FRAME : r_frame_length;
    assign timeout_lim = (r_byte_timeout == 16'd0) ? 16'd1 : r_byte_timeout;
    assign quiet_inc   = r_quiet_ticks + 16'd1;
    assign bytes_inc   = r_bytes_received + 13'd1;
    assign frame_end   = (bytes_inc >= eff_length);
    assign timed_out   = (quiet_inc >= timeout_lim);

    // Next phase and counters.
    always_comb begin
        n_phase          = r_phase;
        n_wait_remaining = r_wait_remaining;
        n_bytes_received = r_bytes_received;
        n_quiet_ticks    = r_quiet_ticks;
        unique case (r_phase)
            PH_WAIT: begin
                if (is_tick || is_sync) begin
                    if (r_wait_remaining <= 16'd1) begin
                        n_wait_remaining = 16'd0;
                        n_phase          = PH_IDLE;
                    end else begin
                        n_wait_remaining = r_wait_remaining - 16'd1;
                    end
                end else if (i_rx.rx_byte == r_start_code) begin
                    n_phase          = PH_RECV;
                    n_bytes_received = 13'd0;
                    n_quiet_ticks    = 16'd0;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_RECV: begin
                if (is_tick) begin
                    if (timed_out) begin
                        n_phase       = PH_IDLE;
                        n_quiet_ticks = 16'd0;
                    end else begin
                        n_quiet_ticks = quiet_inc;
                    end
                end else begin
                    n_bytes_received = bytes_inc;
                    n_quiet_ticks    = 16'd0;
                    if (frame_end) begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            default: begin
                // Idle, and the unused phase code behaves as idle.
                n_phase = PH_IDLE;
                if (is_sync) begin
                    n_phase          = PH_WAIT;
                    n_wait_remaining = START_WAIT_LIMIT;
                end
            end
        endcase
    end

    // Result item for the current input item.
    always_comb begin
        n_res = '0;
        unique case (r_phase)
            PH_WAIT: ;
            PH_RECV: begin
                if (is_tick) begin
                    if (timed_out) begin
                        n_res.send_valid = 1'b1;
                        n_res.send_byte  = r_nak_code;
                        n_res.frame_done = 1'b1;
                    end
                end else begin
                    n_res.data_valid = 1'b1;
                    n_res.data_byte  = i_rx.rx_byte;
                    n_res.data_index = r_bytes_received[11:0];
                    if (frame_end) begin
                        n_res.frame_done = 1'b1;
                        n_res.send_valid = 1'b1;
                        if (i_rx.rx_byte == r_end_code) begin
                            n_res.frame_ok  = 1'b1;
                            n_res.send_byte = r_ack_code;
                        end else begin
                            n_res.send_byte = r_nak_code;
                        end
                    end
                end
            end
            default: begin
                if (is_sync) begin
                    n_res.send_valid = 1'b1;
                    n_res.send_byte  = r_enquiry_code;
                end
            end
        endcase
    end

    // State registers advance on every accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_IDLE;
            r_wait_remaining <= 16'd0;
            r_bytes_received <= 13'd0;
            r_quiet_ticks    <= 16'd0;
        end else if (in_accept) begin
            r_phase          <= n_phase;
            r_wait_remaining <= n_wait_remaining;
            r_bytes_received <= n_bytes_received;
            r_quiet_ticks    <= n_quiet_ticks;
        end
    end

    // Output register valid: loaded only for items that produce a result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= n_res.send_valid || n_res.data_valid || n_res.frame_done;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_res;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.send_valid = r_out.send_valid;
    assign o_res.send_byte  = r_out.send_byte;
    assign o_res.data_valid = r_out.data_valid;
    assign o_res.data_byte  = r_out.data_byte;
    assign o_res.data_index = r_out.data_index;
    assign o_res.frame_done = r_out.frame_done;
    assign o_res.frame_ok   = r_out.frame_ok;

endmodule
